// ----- rtl/efad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder frame angle decoder package
// Shared constants, sequencer types and the divider status struct.
// ----------------------------------------------------------------------------
package efad_pkg;

	localparam int RAW_W   = 16;              // raw count, high and low byte
	localparam int NUM_W   = 25;              // raw * 360 < 2^25
	localparam int DEN_W   = 17;              // counts_per_turn
	localparam int ANGLE_W = 15;
	localparam int DELTA_W = 16;
	localparam int DIFF_W  = 17;              // angle difference before wrap
	localparam int CNT_W   = $clog2(NUM_W + 1);

	localparam logic [7:0]         HDR_FIRST  = 8'hAB;
	localparam logic [7:0]         HDR_SECOND = 8'hCD;
	localparam logic [DEN_W-1:0]   CPT_RESET  = 17'd16384;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 15'h7FFF;
	localparam logic [DIFF_W-1:0]  FULL_TURN  = 17'd360;
	localparam logic [DIFF_W-1:0]  HALF_TURN  = 17'd180;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_GOT_FIRST,
		PH_IN_FRAME
	} efad_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} efad_state_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} efad_div_res_t;

endpackage

// ----- rtl/efad_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one serial byte per item.
// ----------------------------------------------------------------------------
interface efad_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/efad_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle result channel
// Valid/ready channel carrying one decoded angle and its change per item.
// ----------------------------------------------------------------------------
interface efad_out_if;
	logic               valid;
	logic               ready;
	logic [14:0]        angle_deg;
	logic signed [15:0] delta_deg;

	modport source (output valid, output angle_deg, output delta_deg, input ready);
	modport sink   (input valid, input angle_deg, input delta_deg, output ready);
endinterface

// ----- rtl/encoder_frame_angle_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder frame angle decoder
// Frames serial encoder bytes on the 0xAB 0xCD header, divides raw*360 by the
// counts per turn and reports the angle and its wrapped change per frame.
// The last byte of a frame starts the bit-serial divider; its quotient goes
// via ST_FIN to the result register. Throughput: one byte per cycle, but the
// input is stalled from a frame end until that frame's result is loaded.
// Reset: arst_n clears sync, position, previous angle and result valid;
// counts_per_turn returns to 16384.
// ----------------------------------------------------------------------------
module encoder_frame_angle_decoder_core
	import efad_pkg::*;
#(
	parameter int FRAME_BYTES = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	efad_in_if.sink          rx,
	efad_out_if.source       res,
	input  logic             cfg_we,
	input  logic [DEN_W-1:0] cfg_wdata
);

	localparam int POS_W = $clog2(FRAME_BYTES);

	efad_state_t         state_q, state_d;
	efad_phase_t         phase_q;
	logic [POS_W-1:0]    pos_q;
	logic [7:0]          raw_high_q;
	logic [7:0]          raw_low_q;
	logic [ANGLE_W-1:0]  prev_angle_q;
	logic                prev_valid_q;
	logic [DEN_W-1:0]    cpt_q;
	logic                out_valid_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic [DELTA_W-1:0]  delta_q;

	logic                rx_fire;
	logic                frame_end;
	logic                div_start;
	logic                out_load;
	logic                out_free;
	logic [RAW_W-1:0]    raw;
	logic [NUM_W-1:0]    num;
	logic [ANGLE_W-1:0]  angle;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] diff_w;
	logic [DELTA_W-1:0]  delta;
	efad_div_res_t       div_res;

	assign rx_fire   = rx.valid && rx.ready;
	assign frame_end = (phase_q == PH_IN_FRAME) && (pos_q == POS_W'(FRAME_BYTES - 1));
	assign out_free  = !out_valid_q || res.ready;

	// short frames end on the low raw byte itself
	assign raw = {raw_high_q, (pos_q == POS_W'(4)) ? rx.rx_byte : raw_low_q};
	// raw * 360 = raw * (256 + 64 + 32 + 8)
	assign num = (NUM_W'(raw) << 8) + (NUM_W'(raw) << 6)
	           + (NUM_W'(raw) << 5) + (NUM_W'(raw) << 3);

	efad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (cpt_q),
		.res    (div_res)
	);

	assign angle = (div_res.quo > NUM_W'(ANGLE_MAX)) ? ANGLE_MAX
	                                                 : div_res.quo[ANGLE_W-1:0];

	// the wrapped difference always fits the 16-bit result
	always_comb begin
		diff   = $signed({2'b00, angle}) - $signed({2'b00, prev_angle_q});
		diff_w = diff;
		if (diff >= $signed(HALF_TURN)) begin
			diff_w = diff - $signed(FULL_TURN);
		end else if (diff <= -$signed(HALF_TURN)) begin
			diff_w = diff + $signed(FULL_TURN);
		end
		delta = prev_valid_q ? diff_w[DELTA_W-1:0] : '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rx_fire && frame_end) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rx.ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rx.ready  = 1'b1;
				div_start = rx.valid && frame_end;
			end
			ST_DIV: ;
			ST_FIN: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_HUNT;
			pos_q        <= '0;
			prev_angle_q <= '0;
			prev_valid_q <= 1'b0;
			cpt_q        <= CPT_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cpt_q <= cfg_wdata;

			if (out_load) begin
				out_valid_q  <= 1'b1;
				prev_angle_q <= angle;
				prev_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			if (rx_fire) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (rx.rx_byte == HDR_FIRST) phase_q <= PH_GOT_FIRST;
					end
					PH_GOT_FIRST: begin
						if (rx.rx_byte == HDR_SECOND) begin
							phase_q <= PH_IN_FRAME;
							pos_q   <= POS_W'(2);
						end else if (rx.rx_byte != HDR_FIRST) begin
							phase_q <= PH_HUNT;
						end
					end
					PH_IN_FRAME: begin
						if (frame_end) begin
							phase_q <= PH_HUNT;
							pos_q   <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
					default: phase_q <= PH_HUNT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_IN_FRAME) begin
			if (pos_q == POS_W'(3)) raw_high_q <= rx.rx_byte;
			if (pos_q == POS_W'(4)) raw_low_q  <= rx.rx_byte;
		end
		if (out_load) begin
			angle_q <= angle;
			delta_q <= delta;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.angle_deg = angle_q;
	assign res.delta_deg = delta_q;

endmodule

// ----- rtl/efad_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle; a zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module efad_div
	import efad_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output efad_div_res_t    res
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;      // numerator shifts out, quotient shifts in
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;

endmodule

// ----- rtl/efad_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder frame angle decoder checker
// Port-level checks on the result channel and the busy sequencing.
// ----------------------------------------------------------------------------
module efad_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [14:0] angle_deg,
	input logic [15:0] delta_deg
);

	// a held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(angle_deg) && $stable(delta_deg))
		else $error("result changed while stalled");

	// a new result only appears after the divider has kept the input stalled
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!rx_ready))
		else $error("result appeared without a frame end");

	// a frame end does not release the input straight after stalling it
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rx_ready) |=> !rx_ready)
		else $error("busy period too short");

	// busy with an untaken result cannot return to idle
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready && !rx_ready |=> !rx_ready)
		else $error("input reopened with result pending");

endmodule

bind encoder_frame_angle_decoder_core efad_chk u_efad_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.angle_deg (res.angle_deg),
	.delta_deg (res.delta_deg)
);
